### src/vcad_pkg.sv
`default_nettype none
package vcad_pkg;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 48;
   localparam int COUNT_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int GROUP_W  = 16;
   localparam int SIZE_W   = 7;
   localparam int QUOT_W   = 49;

   localparam logic CSR_VECTOR_SIZE = 1'b0;
   localparam logic CSR_DECIMATION  = 1'b1;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic              negative;
      logic [SUM_W-1:0]  magnitude;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;
endpackage
`default_nettype wire

### src/vcad_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle; result saturated to 16 bits.
module vcad_divider (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire vcad_pkg::div_req_type  req,
   output logic                        done,
   output logic [vcad_pkg::SAMPLE_W-1:0] quotient
);
   localparam int CNT_W = $clog2(vcad_pkg::SUM_W + 1);

   logic                           busy_ff, busy_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [vcad_pkg::SUM_W-1:0]     dividend_ff, dividend_in;
   logic [vcad_pkg::COUNT_W:0]     rem_ff, rem_in;
   logic [vcad_pkg::SUM_W-1:0]     quot_ff, quot_in;
   logic [vcad_pkg::COUNT_W-1:0]   div_ff, div_in;
   logic                           neg_ff, neg_in;
   logic                           done_ff, done_in;
   logic [vcad_pkg::COUNT_W:0]     shifted;
   logic [vcad_pkg::COUNT_W+1:0]   diff;
   logic signed [vcad_pkg::QUOT_W-1:0] signed_q;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      dividend_in = dividend_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      shifted = {rem_ff[vcad_pkg::COUNT_W-1:0], dividend_ff[vcad_pkg::SUM_W-1]};
      diff = {1'b0, shifted} - {2'b00, div_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(vcad_pkg::SUM_W);
         dividend_in = req.magnitude;
         rem_in = '0;
         quot_in = '0;
         div_in = req.divisor;
         neg_in = req.negative;
      end else if (busy_ff) begin
         dividend_in = {dividend_ff[vcad_pkg::SUM_W-2:0], 1'b0};
         if (!diff[vcad_pkg::COUNT_W+1]) begin
            rem_in = diff[vcad_pkg::COUNT_W:0];
            quot_in = {quot_ff[vcad_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quot_in = {quot_ff[vcad_pkg::SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dividend_ff <= dividend_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      signed_q = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
      if (signed_q > $signed(vcad_pkg::QUOT_W'(32767)))
         quotient = 16'sh7fff;
      else if (signed_q < -$signed(vcad_pkg::QUOT_W'(32768)))
         quotient = 16'h8000;
      else
         quotient = signed_q[vcad_pkg::SAMPLE_W-1:0];
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (!reset && req.start && busy_ff)
         $error("divider restarted while busy");
   end
endmodule
`default_nettype wire

### src/vector_cumulative_average_decimator_unit.sv
`default_nettype none
// A sample passes through read, update, the divider steps and output; a word that
// emits no result returns to idle after read and update.
// One word at a time: new words are stalled until the unit is idle again.
// A clear sweeps the VECTOR_MAX-entry sum memory (64 by default), one entry a cycle.
// Reset (synchronous, active high) starts a clearing pass over the whole memory;
// registers return to size 1 and decimation 1.
module vector_cumulative_average_decimator_unit #(
   parameter int VECTOR_MAX = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_action,
   input  wire logic signed [15:0]           req_sample,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [15:0]                rsp_average,
   output logic [5:0]                        rsp_element_index,
   output logic                              rsp_last_of_vector,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [15:0]                  csr_data
);
   localparam int AW = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;
   localparam int SW = vcad_pkg::SUM_W;
   localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

   logic [SW-1:0] mem [VECTOR_MAX];
   logic [SW-1:0] rd_ff;

   vcad_pkg::state_type state_ff, state_in;
   logic [vcad_pkg::SIZE_W-1:0]  size_ff;
   logic [vcad_pkg::GROUP_W-1:0] dec_ff;
   logic [vcad_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [5:0]                   elem_ff, elem_in;
   logic [vcad_pkg::GROUP_W-1:0] group_ff, group_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic signed [15:0]           samp_ff;
   logic                         emit_ff, emit_in, last_ff, last_in;
   logic                         out_valid_ff, out_valid_in;
   logic signed [15:0]           avg_ff, avg_in;
   logic [5:0]                   oidx_ff, oidx_in;
   logic                         olast_ff, olast_in;
   logic signed [SW-1:0]         new_sum;
   logic signed [SW:0]           wide_sum;
   logic                         we;
   logic [AW-1:0]                waddr;
   logic [SW-1:0]                wdata;
   logic                         accept;
   logic [6:0]                   eff_size;
   logic [vcad_pkg::GROUP_W-1:0] eff_dec;
   logic [6:0]                   pos_full;
   vcad_pkg::div_req_type        dreq;
   logic                         ddone;
   logic [15:0]                  dq;

   vcad_divider u_div (.clock(clock), .reset(reset), .req(dreq), .done(ddone), .quotient(dq));

   assign eff_size = (size_ff == '0) ? 7'd1 :
                     (size_ff > 7'(VECTOR_MAX)) ? 7'(VECTOR_MAX) : size_ff;
   assign eff_dec = (dec_ff == '0) ? 16'd1 : dec_ff;
   assign pos_full = ({1'b0, elem_ff} >= eff_size) ? eff_size - 7'd1 : {1'b0, elem_ff};
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != vcad_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign wide_sum = {rd_ff[SW-1], rd_ff} + (SW+1)'(samp_ff);
   always_comb begin
      if (wide_sum > (SW+1)'(SUM_MAX) && !wide_sum[SW])
         new_sum = SUM_MAX;
      else if (wide_sum[SW] && !wide_sum[SW-1])
         new_sum = SUM_MIN;
      else
         new_sum = wide_sum[SW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vcad_pkg::ST_IDLE:
            if (accept)
               state_in = (req_action == vcad_pkg::ACTION_CLEAR) ?
                          vcad_pkg::ST_CLEAR : vcad_pkg::ST_READ;
         vcad_pkg::ST_CLEAR:
            if (clr_ff == AW'(VECTOR_MAX - 1)) state_in = vcad_pkg::ST_IDLE;
         vcad_pkg::ST_READ:   state_in = vcad_pkg::ST_UPDATE;
         vcad_pkg::ST_UPDATE:
            state_in = emit_ff ? vcad_pkg::ST_DIVIDE : vcad_pkg::ST_IDLE;
         vcad_pkg::ST_DIVIDE:
            if (ddone) state_in = vcad_pkg::ST_OUTPUT;
         // hold until the output register is free
         vcad_pkg::ST_OUTPUT:
            if (!(out_valid_ff && rsp_stall)) state_in = vcad_pkg::ST_IDLE;
         default: state_in = vcad_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      count_in = count_ff;
      elem_in = elem_ff;
      group_in = group_ff;
      clr_in = clr_ff;
      pos_in = pos_ff;
      emit_in = emit_ff;
      last_in = last_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      avg_in = avg_ff;
      oidx_in = oidx_ff;
      olast_in = olast_ff;
      we = 1'b0;
      waddr = pos_ff;
      wdata = new_sum;
      dreq = '0;
      unique case (state_ff)
         vcad_pkg::ST_IDLE:
            if (accept) begin
               if (req_action == vcad_pkg::ACTION_CLEAR) begin
                  count_in = '0;
                  clr_in = '0;
               end else begin
                  pos_in = AW'(pos_full);
                  if (elem_ff == '0 && count_ff != '1) count_in = count_ff + 1'b1;
                  last_in = ({1'b0, elem_ff} + 7'd1) >= eff_size;
                  emit_in = ({1'b0, group_ff} + 17'd1) >= {1'b0, eff_dec};
                  if (({1'b0, elem_ff} + 7'd1) >= eff_size) begin
                     elem_in = '0;
                     group_in = (({1'b0, group_ff} + 17'd1) >= {1'b0, eff_dec}) ?
                                '0 : group_ff + 1'b1;
                  end else begin
                     elem_in = elem_ff + 1'b1;
                  end
               end
            end
         vcad_pkg::ST_CLEAR: begin
            we = 1'b1;
            waddr = clr_ff;
            wdata = '0;
            clr_in = clr_ff + 1'b1;
         end
         vcad_pkg::ST_READ: ;
         vcad_pkg::ST_UPDATE: begin
            we = 1'b1;
            if (emit_ff) begin
               if (count_ff == '0) begin
                  dreq = '0;
               end else begin
                  dreq.start = 1'b1;
                  dreq.negative = new_sum[SW-1];
                  dreq.magnitude = new_sum[SW-1] ? -new_sum : new_sum;
                  dreq.divisor = count_ff;
               end
            end
         end
         vcad_pkg::ST_DIVIDE: ;
         vcad_pkg::ST_OUTPUT:
            if (!(out_valid_ff && rsp_stall)) begin
               out_valid_in = 1'b1;
               avg_in = (count_ff == '0) ? '0 : dq;
               oidx_in = 6'(pos_ff);
               olast_in = last_ff;
            end
         default: ;
      endcase
   end

   // zero count: skip divider, go straight to output
   logic zero_bypass;
   assign zero_bypass = (state_ff == vcad_pkg::ST_DIVIDE) && (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vcad_pkg::ST_CLEAR;
         clr_ff <= '0;
         size_ff <= 7'd1;
         dec_ff <= 16'd1;
         count_ff <= '0;
         elem_ff <= '0;
         group_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= zero_bypass ? vcad_pkg::ST_OUTPUT : state_in;
         clr_ff <= clr_in;
         count_ff <= count_in;
         elem_ff <= elem_in;
         group_ff <= group_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == vcad_pkg::CSR_VECTOR_SIZE) size_ff <= csr_data[6:0];
            else dec_ff <= csr_data;
         end
      end
      pos_ff <= pos_in;
      emit_ff <= emit_in;
      last_ff <= last_in;
      avg_ff <= avg_in;
      oidx_ff <= oidx_in;
      olast_ff <= olast_in;
      if (accept) samp_ff <= req_sample;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[pos_ff];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_average = avg_ff;
   assign rsp_element_index = oidx_ff;
   assign rsp_last_of_vector = olast_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != vcad_pkg::ST_IDLE) |-> !accept) else $error("accept while busy");
   a_out_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == vcad_pkg::ST_OUTPUT))
      else $error("result without output state");
   a_elem_bound: assert property (@(posedge clock) disable iff (reset)
      (elem_ff < 6'(VECTOR_MAX)) || (VECTOR_MAX == 64)) else $error("element out of range");
endmodule
`default_nettype wire
